### rtl/fbas_pkg.sv
package fbas_pkg;

   localparam int QUEUE_DEPTH = 256;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int MARK_W      = 10;
   localparam int CMP_W       = ((FILL_W > MARK_W) ? FILL_W : MARK_W) + 1;
   localparam int BYTE_W      = 8;
   localparam int PIN_W       = 2;
   localparam int SLOT_W      = 2;
   localparam int CNT_W       = 32;
   localparam int FILL_OUT_W  = 9;
   localparam int REQ_W       = 24;
   localparam int RSP_W       = 48;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(3);
   localparam logic [PIN_W-1:0]  START_PIN = PIN_W'(8'hfc & 8'h03);
   localparam logic [MARK_W-1:0] MARK_OFF  = '1;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_PUSH  = 3'd1,
      CMD_MARK  = 3'd2,
      CMD_START = 3'd3,
      CMD_STOP  = 3'd4
   } cmd_type;

   // packed so that the first field sits in the highest bits
   typedef struct packed {
      logic [CNT_W-1:0]      samples_played;
      logic [FILL_OUT_W-1:0] fill_level;
      logic                  push_accepted;
      logic                  underrun;
      logic                  wake;
      logic [PIN_W-1:0]      pin_level;
   } rsp_type;

   function automatic logic [BYTE_W-1:0] rotl2(input logic [BYTE_W-1:0] b);
      rotl2 = {b[BYTE_W-3:0], b[BYTE_W-1:BYTE_W-2]};
   endfunction

endpackage

### rtl/fifo_fed_two_bit_audio_serializer_core.sv
// two-bit audio serializer fed by a byte fifo
//
// req channel: one beat per command (tick, push byte, set low-water mark,
//   start, stop); every beat yields exactly one rsp beat
// rsp channel: pin level, wake, underrun, push accepted, fill level and the
//   sample count after the command
// rsp path: each result is combinational and is registered in the output stage
// throughput: one command per cycle while req_tready is high; the fifo bytes
//   live in a ram with a registered read, and a popped byte is folded into
//   the shift register by forwarding the ram output on the following cycle
// reset: fifo empty, playback stopped, mark disabled (-1), pins and sample
//   count zero; no clearing pass, so commands are taken right after reset
// receiver stall: the output register plus a one-beat skid buffer hold
//   results; req_tready drops only once the skid buffer is full
module fifo_fed_two_bit_audio_serializer_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // cmd[2:0], data_byte[10:3], watermark_level[20:11], zero pad
   input  logic [fbas_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // pin_level[1:0], wake[2], underrun[3], push_accepted[4],
   // fill_level[13:5], samples_played[45:14], zero pad
   output logic [fbas_pkg::RSP_W-1:0] rsp_tdata
);

   logic                        accept;
   logic                        wr_en;
   logic [fbas_pkg::PTR_W-1:0]  wr_addr, rd_addr;
   logic [fbas_pkg::BYTE_W-1:0] wr_data, rd_data;
   fbas_pkg::rsp_type           result, rsp_data;

   assign accept = req_tvalid && req_tready;

   // command decode, pointers, shift byte and counters
   fbas_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .cmd             (req_tdata[2:0]),
      .data_byte       (req_tdata[10:3]),
      .watermark_level (req_tdata[20:11]),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .result          (result)
   );

   // fifo byte store
   fbas_ram #(
      .WIDTH (fbas_pkg::BYTE_W),
      .DEPTH (fbas_pkg::QUEUE_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register with skid buffer
   fbas_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {{(fbas_pkg::RSP_W - $bits(fbas_pkg::rsp_type)){1'b0}}, rsp_data};

endmodule

### rtl/fbas_ram.sv
module fbas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fbas_ctrl.sv
module fbas_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [2:0]                    cmd,
   input  logic [fbas_pkg::BYTE_W-1:0]   data_byte,
   input  logic [fbas_pkg::MARK_W-1:0]   watermark_level,
   output logic                          wr_en,
   output logic [fbas_pkg::PTR_W-1:0]    wr_addr,
   output logic [fbas_pkg::BYTE_W-1:0]   wr_data,
   output logic [fbas_pkg::PTR_W-1:0]    rd_addr,
   input  logic [fbas_pkg::BYTE_W-1:0]   rd_data,
   output fbas_pkg::rsp_type             result
);

   logic [fbas_pkg::PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [fbas_pkg::PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [fbas_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [fbas_pkg::BYTE_W-1:0] shift_ff, shift_in, shift_eff;
   logic [fbas_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                        playing_ff, playing_in;
   logic [fbas_pkg::MARK_W-1:0] mark_ff, mark_in;
   logic [fbas_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [fbas_pkg::PIN_W-1:0]  pin_ff, pin_in;
   logic                        pend_ff, pend_in;
   logic                        wake, underrun, pushed;
   logic signed [fbas_pkg::CMP_W-1:0] fill_cmp, mark_cmp;

   // popped byte arrives from the ram in the cycle after the pop; fold it in here
   assign shift_eff = pend_ff ? fbas_pkg::rotl2(rd_data) : shift_ff;

   assign mark_cmp = $signed({{(fbas_pkg::CMP_W - fbas_pkg::MARK_W){mark_ff[fbas_pkg::MARK_W-1]}},
                              mark_ff});

   assign wr_addr = wr_ptr_ff;
   assign wr_data = data_byte;
   assign rd_addr = rd_ptr_ff;

   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      fill_in    = fill_ff;
      shift_in   = shift_eff;
      slot_in    = slot_ff;
      playing_in = playing_ff;
      mark_in    = mark_ff;
      cnt_in     = cnt_ff;
      pin_in     = pin_ff;
      pend_in    = 1'b0;
      wr_en      = 1'b0;
      pushed     = 1'b0;
      wake       = 1'b0;
      underrun   = 1'b0;
      fill_cmp   = '0;
      if (accept) begin
         unique case (fbas_pkg::cmd_type'(cmd))
            fbas_pkg::CMD_PUSH: begin
               if (fill_ff != fbas_pkg::FILL_W'(fbas_pkg::QUEUE_DEPTH)) begin
                  wr_en     = 1'b1;
                  pushed    = 1'b1;
                  fill_in   = fill_ff + 1'b1;
                  wr_ptr_in = (wr_ptr_ff == fbas_pkg::PTR_W'(fbas_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_ff + 1'b1;
               end
            end
            fbas_pkg::CMD_MARK: begin
               mark_in = watermark_level;
            end
            fbas_pkg::CMD_START: begin
               rd_ptr_in  = '0;
               wr_ptr_in  = '0;
               fill_in    = '0;
               pin_in     = fbas_pkg::START_PIN;
               mark_in    = fbas_pkg::MARK_OFF;
               cnt_in     = '0;
               slot_in    = '0;
               playing_in = 1'b1;
            end
            fbas_pkg::CMD_STOP: begin
               playing_in = 1'b0;
            end
            fbas_pkg::CMD_TICK: begin
               if (playing_ff) begin
                  pin_in = shift_eff[fbas_pkg::PIN_W-1:0];
                  if (slot_ff == '0) begin
                     if (fill_ff != '0) begin
                        // pop: the byte is rotated once when it lands next cycle
                        pend_in   = 1'b1;
                        fill_in   = fill_ff - 1'b1;
                        rd_ptr_in = (rd_ptr_ff == fbas_pkg::PTR_W'(fbas_pkg::QUEUE_DEPTH - 1)) ?
                                    '0 : rd_ptr_ff + 1'b1;
                        slot_in   = fbas_pkg::LAST_SLOT;
                        cnt_in    = cnt_ff + 1'b1;
                     end
                  end else begin
                     shift_in = fbas_pkg::rotl2(shift_eff);
                     slot_in  = slot_ff - 1'b1;
                     cnt_in   = cnt_ff + 1'b1;
                  end
                  fill_cmp = $signed({{(fbas_pkg::CMP_W - fbas_pkg::FILL_W){1'b0}}, fill_in});
                  if (fill_cmp <= mark_cmp) begin
                     wake     = 1'b1;
                     underrun = (mark_ff != '0) && (fill_in == '0);
                     mark_in  = fbas_pkg::MARK_OFF;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
         fill_ff    <= '0;
         shift_ff   <= '0;
         slot_ff    <= '0;
         playing_ff <= 1'b0;
         mark_ff    <= fbas_pkg::MARK_OFF;
         cnt_ff     <= '0;
         pin_ff     <= '0;
         pend_ff    <= 1'b0;
      end else begin
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         fill_ff    <= fill_in;
         shift_ff   <= shift_in;
         slot_ff    <= slot_in;
         playing_ff <= playing_in;
         mark_ff    <= mark_in;
         cnt_ff     <= cnt_in;
         pin_ff     <= pin_in;
         pend_ff    <= pend_in;
      end
   end

   assign result.pin_level      = pin_in;
   assign result.wake           = wake;
   assign result.underrun       = underrun;
   assign result.push_accepted  = pushed;
   assign result.fill_level     = fbas_pkg::FILL_OUT_W'(fill_in);
   assign result.samples_played = cnt_in;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fbas_pkg::FILL_W'(fbas_pkg::QUEUE_DEPTH))
      else $error("fifo fill above depth");

   a_pend_slot: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (slot_ff == fbas_pkg::LAST_SLOT))
      else $error("pending byte without fresh slot count");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pend_in |-> (fill_ff != '0))
      else $error("pop from empty fifo");
`endif

endmodule

### rtl/fbas_skid.sv
module fbas_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fbas_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fbas_pkg::rsp_type out_data
);

   logic              out_valid_ff, skid_valid_ff;
   fbas_pkg::rsp_type out_data_ff, skid_data_ff;
   logic              in_acc, load_out;

   assign in_ready = !skid_valid_ff;
   assign in_acc   = in_valid && in_ready;
   assign load_out = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (load_out) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_acc;
         end
      end else if (in_acc) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_acc) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while output is empty");
`endif

endmodule

### sim/fifo_fed_two_bit_audio_serializer_core_tb.sv
module fifo_fed_two_bit_audio_serializer_core_tb;

   // codes past stop are spare: the block must leave its state alone
   localparam logic [2:0] SPARE_CMD_FIRST = 3'd5;
   localparam logic [2:0] SPARE_CMD_LAST  = 3'd7;
   localparam int         TARGET_ITEMS    = 1925;
   localparam int         TAIL_CYCLES     = 8;

   typedef struct {
      logic [2:0]                  cmd;
      logic [fbas_pkg::BYTE_W-1:0] data;
      logic [fbas_pkg::MARK_W-1:0] level;
      bit                          hold;  // wait for all results before this beat
   } cmd_beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [fbas_pkg::REQ_W-1:0] req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [fbas_pkg::RSP_W-1:0] rsp_tdata;

   fifo_fed_two_bit_audio_serializer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1;
      clock = 1'b1;
      #1;
      clock = 1'b0;
   end

   cmd_beat_type      pending_cmds[$];
   fbas_pkg::rsp_type predicted_rsp[$];
   int                error_count   = 0;
   int                counted_items = 0;
   bit                hold_next     = 1'b0;
   bit                feed_done     = 1'b0;
   bit                results_idle  = 1'b1;

   // predictor state, a mirror of the serializer
   logic [fbas_pkg::BYTE_W-1:0] fifo_copy [fbas_pkg::QUEUE_DEPTH];
   int                          rd_ptr       = 0;
   int                          wr_ptr       = 0;
   int                          fill_count   = 0;
   logic [fbas_pkg::BYTE_W-1:0] shift_copy   = '0;
   int                          slots_left   = 0;
   bit                          playing      = 1'b0;
   int                          low_mark     = -1;
   logic [fbas_pkg::CNT_W-1:0]  played_count = '0;
   logic [fbas_pkg::PIN_W-1:0]  pin_copy     = '0;

   function automatic fbas_pkg::rsp_type serializer_step(logic [2:0] cmd,
                                                         logic [fbas_pkg::BYTE_W-1:0] data,
                                                         logic [fbas_pkg::MARK_W-1:0] level);
      fbas_pkg::rsp_type r;
      bit                advance;
      r = '0;
      case (cmd)
         fbas_pkg::CMD_PUSH: begin
            if (fill_count < fbas_pkg::QUEUE_DEPTH) begin
               fifo_copy[wr_ptr] = data;
               wr_ptr = (wr_ptr + 1) % fbas_pkg::QUEUE_DEPTH;
               fill_count++;
               r.push_accepted = 1'b1;
            end
         end
         fbas_pkg::CMD_MARK: begin
            low_mark = $signed(level);
         end
         fbas_pkg::CMD_START: begin
            rd_ptr       = 0;
            wr_ptr       = 0;
            fill_count   = 0;
            pin_copy     = fbas_pkg::START_PIN;
            low_mark     = -1;
            played_count = '0;
            slots_left   = 0;
            playing      = 1'b1;
         end
         fbas_pkg::CMD_STOP: begin
            playing = 1'b0;
         end
         fbas_pkg::CMD_TICK: begin
            if (playing) begin
               advance  = 1'b1;
               pin_copy = shift_copy[fbas_pkg::PIN_W-1:0];
               if (slots_left == 0) begin
                  if (fill_count == 0) begin
                     // starved: hold the shift byte and the count
                     advance = 1'b0;
                  end else begin
                     shift_copy = fifo_copy[rd_ptr];
                     rd_ptr     = (rd_ptr + 1) % fbas_pkg::QUEUE_DEPTH;
                     fill_count--;
                     slots_left = 4;
                  end
               end
               if (advance) begin
                  shift_copy = {shift_copy[fbas_pkg::BYTE_W-3:0],
                                shift_copy[fbas_pkg::BYTE_W-1:fbas_pkg::BYTE_W-2]};
                  slots_left--;
                  played_count++;
               end
               // signed compare, a negative mark never fires
               if (fill_count <= low_mark) begin
                  r.wake     = 1'b1;
                  r.underrun = (low_mark != 0 && fill_count == 0);
                  low_mark   = -1;
               end
            end
         end
         default: begin
         end
      endcase
      r.pin_level      = pin_copy;
      r.fill_level     = fill_count[fbas_pkg::FILL_OUT_W-1:0];
      r.samples_played = played_count;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   function automatic void add_beat(logic [2:0] cmd, logic [fbas_pkg::BYTE_W-1:0] data,
                                    logic [fbas_pkg::MARK_W-1:0] level);
      cmd_beat_type b;
      b.cmd   = cmd;
      b.data  = data;
      b.level = level;
      b.hold  = hold_next;
      hold_next = 1'b0;
      pending_cmds.push_back(b);
      if (cmd <= fbas_pkg::CMD_STOP) counted_items++;
   endfunction

   // same, with random filler in the unused fields
   function automatic void add_cmd(logic [2:0] cmd);
      add_beat(cmd, fbas_pkg::BYTE_W'($urandom), fbas_pkg::MARK_W'($urandom));
   endfunction

   // sender: bursts and gaps, one beat held until taken
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      cmd_beat_type head;
      bit           took;
      if (reset) begin
         req_tvalid <= 1'b0;
         feed_done  <= 1'b0;
      end else begin
         took = req_tvalid && req_tready;
         if (!req_tvalid || took) begin
            feed_done <= (pending_cmds.size() == 0);
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_cmds[0].hold && (took || !results_idle)) begin
               // pause until every result is back
               req_tvalid <= 1'b0;
            end else begin
               head = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, head.level, head.data, head.cmd};
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // receiver: stall style changes with bits 9:8 of a free-running cycle counter
   logic [15:0] stall_cycle = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_cycle <= stall_cycle + 16'd1;
         case (stall_cycle[9:8])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= 1'($urandom_range(0, 1));
            2'd2: rsp_tready <= (stall_cycle[2:0] == 3'd0);
            default: rsp_tready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // monitor: predict on each req beat, compare each rsp beat
   always @(posedge clock) begin
      fbas_pkg::rsp_type got;
      fbas_pkg::rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            // req_tdata: cmd[2:0], data_byte[10:3], watermark_level[20:11]
            predicted_rsp.push_back(serializer_step(req_tdata[2:0], req_tdata[10:3],
                                                    req_tdata[20:11]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(fbas_pkg::rsp_type)-1:0];
            if (predicted_rsp.size() == 0) begin
               $error("rsp beat with no command waiting: %h", rsp_tdata);
               error_count++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("pin_level", want.pin_level, got.pin_level);
               check_field("wake", want.wake, got.wake);
               check_field("underrun", want.underrun, got.underrun);
               check_field("push_accepted", want.push_accepted, got.push_accepted);
               check_field("fill_level", want.fill_level, got.fill_level);
               check_field("samples_played", want.samples_played, got.samples_played);
            end
         end
         results_idle <= (predicted_rsp.size() == 0);
      end
   end

   initial begin
      int kind;
      int seq;
      int fills;
      int k;
      int n;
      int m;

      // directed: stopped block, spare codes, mark extremes, starve, wake paths
      add_beat(fbas_pkg::CMD_TICK, 8'hff, fbas_pkg::MARK_OFF);
      for (int c = SPARE_CMD_FIRST; c <= SPARE_CMD_LAST; c++) begin
         add_beat(3'(c), 8'hff, fbas_pkg::MARK_OFF);
      end
      add_beat(fbas_pkg::CMD_PUSH, 8'h00, 10'h000);
      add_cmd(fbas_pkg::CMD_STOP);
      add_beat(fbas_pkg::CMD_MARK, 8'h00, 10'h1ff);
      add_beat(fbas_pkg::CMD_MARK, 8'hff, 10'h200);
      add_cmd(fbas_pkg::CMD_START);
      add_beat(fbas_pkg::CMD_TICK, 8'h00, 10'h000);
      add_beat(fbas_pkg::CMD_PUSH, 8'he4, 10'h3ff);
      add_beat(fbas_pkg::CMD_PUSH, 8'hff, 10'h000);
      add_beat(fbas_pkg::CMD_MARK, 8'h00, 10'd1);
      repeat (5) add_cmd(fbas_pkg::CMD_TICK);
      add_beat(fbas_pkg::CMD_MARK, 8'h00, 10'd256);
      add_cmd(fbas_pkg::CMD_TICK);
      add_beat(fbas_pkg::CMD_MARK, 8'h00, 10'd0);
      add_cmd(fbas_pkg::CMD_TICK);
      add_cmd(fbas_pkg::CMD_STOP);
      add_cmd(fbas_pkg::CMD_TICK);
      add_beat(fbas_pkg::CMD_PUSH, 8'h5a, 10'h155);

      // random sequences, mostly well-formed playback
      seq   = 0;
      fills = 0;
      while (counted_items < TARGET_ITEMS) begin
         kind      = (seq == 0) ? 95 : $urandom_range(0, 99);
         hold_next = (seq == 0) || ($urandom_range(0, 9) == 0);
         if (kind >= 93 && fills < 3) begin
            // overfill, mark near the top, drain a little, refill past full
            fills++;
            add_cmd(fbas_pkg::CMD_START);
            repeat (fbas_pkg::QUEUE_DEPTH + $urandom_range(1, 4)) add_cmd(fbas_pkg::CMD_PUSH);
            add_beat(fbas_pkg::CMD_MARK, 8'h00,
                     fbas_pkg::MARK_W'($urandom_range(fbas_pkg::QUEUE_DEPTH - 16,
                                                      fbas_pkg::QUEUE_DEPTH)));
            repeat ($urandom_range(1, 12)) add_cmd(fbas_pkg::CMD_TICK);
            repeat ($urandom_range(1, 6)) add_cmd(fbas_pkg::CMD_PUSH);
            repeat ($urandom_range(0, 6)) add_cmd(fbas_pkg::CMD_TICK);
         end else if (kind >= 85 && kind < 93) begin
            // broken flow: stop mid stream, restart on an empty fifo
            add_cmd(fbas_pkg::CMD_STOP);
            repeat ($urandom_range(1, 4)) add_cmd(fbas_pkg::CMD_TICK);
            repeat ($urandom_range(0, 3)) add_cmd(fbas_pkg::CMD_PUSH);
            add_cmd(fbas_pkg::CMD_START);
            repeat ($urandom_range(1, 4)) add_cmd(fbas_pkg::CMD_TICK);
            add_beat(fbas_pkg::CMD_MARK, fbas_pkg::BYTE_W'($urandom), 10'd0);
            repeat ($urandom_range(1, 3)) add_cmd(fbas_pkg::CMD_TICK);
         end else if (kind >= 72 && kind < 85) begin
            // any mark value, positive or negative
            add_cmd(fbas_pkg::CMD_MARK);
            repeat ($urandom_range(1, 6)) add_cmd(fbas_pkg::CMD_TICK);
         end else if (kind >= 60 && kind < 72) begin
            // noise over every code
            repeat ($urandom_range(3, 15)) add_cmd(3'($urandom_range(0, SPARE_CMD_LAST)));
         end else begin
            if ($urandom_range(0, 4) != 0) add_cmd(fbas_pkg::CMD_START);
            k = $urandom_range(0, 10);
            repeat (k) add_cmd(fbas_pkg::CMD_PUSH);
            if ($urandom_range(0, 1) == 1) begin
               m = $urandom_range(0, k + 1);
               add_beat(fbas_pkg::CMD_MARK, fbas_pkg::BYTE_W'($urandom),
                        fbas_pkg::MARK_W'(m - 1));
            end
            n = $urandom_range(0, 4 * k + 8);
            repeat (n) begin
               m = $urandom_range(0, 19);
               if (m == 0) begin
                  add_cmd(fbas_pkg::CMD_PUSH);
               end else if (m == 1) begin
                  m = $urandom_range(0, 6);
                  add_beat(fbas_pkg::CMD_MARK, fbas_pkg::BYTE_W'($urandom),
                           fbas_pkg::MARK_W'(m - 1));
               end else begin
                  add_cmd(fbas_pkg::CMD_TICK);
               end
            end
            if ($urandom_range(0, 5) == 0) begin
               add_cmd(fbas_pkg::CMD_STOP);
               repeat ($urandom_range(1, 3)) add_cmd(fbas_pkg::CMD_TICK);
            end
         end
         seq++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (!(feed_done && results_idle));
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### fifo_fed_two_bit_audio_serializer_core.f
rtl/fbas_pkg.sv
rtl/fbas_ram.sv
rtl/fbas_ctrl.sv
rtl/fbas_skid.sv
rtl/fifo_fed_two_bit_audio_serializer_core.sv
sim/fifo_fed_two_bit_audio_serializer_core_tb.sv
